/* rtl/lgbs_pkg.sv */
// Package for the launch grid block splitter.
// Holds field widths, status and register codes, and the control types of the
// shared multiply/divide unit. No dependencies.
package lgbs_pkg;

  localparam int EXT_W = 31;
  localparam int LIM_W = 11;
  localparam int BLK_W = 34;
  localparam int THR_W = 12;
  localparam logic [THR_W-1:0] THR_SAT = 12'd2048;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXTENT    = 2'd1;
  localparam logic [1:0] ST_GIVEN_THR = 2'd2;
  localparam logic [1:0] ST_AUTO_THR  = 2'd3;

  localparam logic [2:0] REG_MAX_BLOCK_X = 3'd0;
  localparam logic [2:0] REG_MAX_BLOCK_Y = 3'd1;
  localparam logic [2:0] REG_MAX_BLOCK_Z = 3'd2;
  localparam logic [2:0] REG_MAX_GRID_X  = 3'd3;
  localparam logic [2:0] REG_MAX_GRID_Y  = 3'd4;
  localparam logic [2:0] REG_MAX_GRID_Z  = 3'd5;
  localparam logic [2:0] REG_MAX_THREADS = 3'd6;

  typedef enum logic {MDU_MUL, MDU_DIV} mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_rsp_t;

endpackage

/* rtl/launch_grid_block_splitter.sv */
// Launch grid block splitter: one request in, one result beat out.
// The work is data dependent: one extent check per dimension, then with given tiles
// one divide per dimension, or in automatic mode a multiply and a modulo per rho step,
// a divide per gcd remainder and a divide and a multiply per factor, all on the shared
// multiply/divide unit. One request is in work at a time; in_tready is low meanwhile.
// Reset is synchronous, active low, and loads the limit registers.
module launch_grid_block_splitter (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // num_dims[1:0], global_x[32:2], global_y[63:33], global_z[94:64],
  // local_x[125:95], local_y[156:126], local_z[187:157], zero fill above
  input  logic [191:0] in_tdata,
  // tile_given[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // grid_x[30:0], grid_y[61:31], grid_z[92:62], block_x[123:93],
  // block_y[154:124], block_z[185:155], status[187:186], zero fill above
  output logic [191:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  localparam int EW = lgbs_pkg::EXT_W;
  localparam int LW = lgbs_pkg::LIM_W;
  localparam int BW = lgbs_pkg::BLK_W;
  localparam int TW = lgbs_pkg::THR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_EXT, S_BLK, S_BLKW, S_GLOOP, S_AFIN, S_RHO, S_SQ, S_MOD,
    S_GCD, S_GCDW, S_APPLY, S_EXACT, S_BMUL, S_OUT
  } state_t;

  state_t          state_r;
  logic [LW-1:0]   mb_r [3];
  logic [EW-1:0]   mg_r [3];
  logic [LW-1:0]   mt_r;
  logic [1:0]      dims_r;
  logic [1:0]      dim_r;
  logic            given_r;
  logic [EW-1:0]   glob_r [3];
  logic [EW-1:0]   loc_r [3];
  logic [EW-1:0]   grid_r [3];
  logic [BW-1:0]   blk_r [3];
  logic [1:0]      status_r;
  logic [TW-1:0]   thr_r;
  // Rho iteration state: modulus, walk value, anchor, round length, step, factor.
  logic [EW-1:0]   n_r;
  logic [EW-1:0]   x_r;
  logic [EW-1:0]   anchor_r;
  logic [39:0]     span_r;
  logic [39:0]     k_r;
  logic [EW-1:0]   f_r;
  logic [EW-1:0]   ga_r;
  logic [EW-1:0]   gb_r;
  logic            out_valid_r;
  logic [191:0]    out_data_r;

  lgbs_pkg::mdu_req_t mdu_req;
  lgbs_pkg::mdu_rsp_t mdu_rsp;
  logic [63:0]        mdu_opa;
  logic [BW-1:0]      mdu_opb;
  logic [63:0]        mdu_res;
  logic [BW-1:0]      mdu_rem;

  logic [EW-1:0]      cur_glob;
  logic [EW-1:0]      cur_loc;
  logic [EW-1:0]      cur_mb;
  logic [EW-1:0]      cur_mg;
  logic [EW+LW-1:0]   ext_lim;
  logic [EW-1:0]      b_lim;
  logic [EW-1:0]      b_sel;
  logic               last_dim;
  logic [EW-1:0]      x_new;
  logic [EW-1:0]      d_abs;
  logic [EW:0]        ceil_num;

  function automatic logic [TW-1:0] thr_mul(logic [TW-1:0] t, logic [BW-1:0] v);
    logic [TW-1:0]   vs;
    logic [2*TW-1:0] p;
    vs = (v > BW'(2047)) ? lgbs_pkg::THR_SAT : v[TW-1:0];
    p  = t * vs;
    return (p > (2*TW)'(2047)) ? lgbs_pkg::THR_SAT : p[TW-1:0];
  endfunction

  lgbs_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .opa   (mdu_opa),
    .opb   (mdu_opb),
    .rsp   (mdu_rsp),
    .res   (mdu_res),
    .rem   (mdu_rem)
  );

  assign cur_glob = glob_r[dim_r];
  assign cur_loc  = loc_r[dim_r];
  assign cur_mb   = EW'(mb_r[dim_r]);
  assign cur_mg   = mg_r[dim_r];
  assign ext_lim  = mb_r[dim_r] * mg_r[dim_r];
  assign b_lim    = (cur_glob < cur_mb) ? cur_glob : cur_mb;
  assign b_sel    = (given_r && (cur_loc < b_lim)) ? cur_loc : b_lim;
  assign last_dim = (dim_r == dims_r - 2'd1);
  assign ceil_num = {1'b0, cur_glob} + {1'b0, b_sel} - (EW+1)'(1);
  assign x_new    = mdu_rem[EW-1:0];
  assign d_abs    = (x_new >= anchor_r) ? (x_new - anchor_r) : (anchor_r - x_new);

  // The shared unit is started from the sequencer state that needs it.
  always_comb begin
    mdu_req.start = 1'b0;
    mdu_req.op    = lgbs_pkg::MDU_DIV;
    mdu_opa       = '0;
    mdu_opb       = '0;
    case (state_r)
      S_BLK: begin
        mdu_req.start = given_r;
        mdu_opa       = 64'(ceil_num);
        mdu_opb       = BW'(b_sel);
      end
      S_RHO: begin
        mdu_req.start = (k_r <= span_r) && (f_r <= EW'(1));
        mdu_req.op    = lgbs_pkg::MDU_MUL;
        mdu_opa       = 64'(x_r);
        mdu_opb       = BW'(x_r);
      end
      S_SQ: begin
        mdu_req.start = mdu_rsp.done;
        mdu_opa       = mdu_res + 64'd1;
        mdu_opb       = BW'(n_r);
      end
      S_GCD: begin
        mdu_req.start = (gb_r != '0);
        mdu_opa       = 64'(ga_r);
        mdu_opb       = BW'(gb_r);
      end
      S_APPLY: begin
        mdu_req.start = (f_r != n_r);
        mdu_opa       = 64'(n_r);
        mdu_opb       = BW'(f_r);
      end
      S_EXACT: begin
        mdu_req.start = mdu_rsp.done;
        mdu_req.op    = lgbs_pkg::MDU_MUL;
        mdu_opa       = 64'(blk_r[dim_r]);
        mdu_opb       = BW'(f_r);
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mb_r[0]     <= 11'd1024;
      mb_r[1]     <= 11'd1024;
      mb_r[2]     <= 11'd64;
      mg_r[0]     <= 31'd2147483647;
      mg_r[1]     <= 31'd65535;
      mg_r[2]     <= 31'd65535;
      mt_r        <= 11'd1024;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          lgbs_pkg::REG_MAX_BLOCK_X: mb_r[0] <= cfg_data[LW-1:0];
          lgbs_pkg::REG_MAX_BLOCK_Y: mb_r[1] <= cfg_data[LW-1:0];
          lgbs_pkg::REG_MAX_BLOCK_Z: mb_r[2] <= cfg_data[LW-1:0];
          lgbs_pkg::REG_MAX_GRID_X:  mg_r[0] <= cfg_data;
          lgbs_pkg::REG_MAX_GRID_Y:  mg_r[1] <= cfg_data;
          lgbs_pkg::REG_MAX_GRID_Z:  mg_r[2] <= cfg_data;
          lgbs_pkg::REG_MAX_THREADS: mt_r    <= cfg_data[LW-1:0];
          default: ;
        endcase
      end

      // In S_OUT the output register is reloaded below when it is empty or its beat leaves.
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            // A zero dimension count, extent or tile is taken as one.
            dims_r    <= (in_tdata[1:0] == 2'd0) ? 2'd1 : in_tdata[1:0];
            given_r   <= in_tuser;
            glob_r[0] <= (in_tdata[32:2] == '0) ? EW'(1) : in_tdata[32:2];
            glob_r[1] <= (in_tdata[63:33] == '0) ? EW'(1) : in_tdata[63:33];
            glob_r[2] <= (in_tdata[94:64] == '0) ? EW'(1) : in_tdata[94:64];
            loc_r[0]  <= (in_tdata[125:95] == '0) ? EW'(1) : in_tdata[125:95];
            loc_r[1]  <= (in_tdata[156:126] == '0) ? EW'(1) : in_tdata[156:126];
            loc_r[2]  <= (in_tdata[187:157] == '0) ? EW'(1) : in_tdata[187:157];
            for (int i = 0; i < 3; i++) begin
              grid_r[i] <= EW'(1);
              blk_r[i]  <= BW'(1);
            end
            status_r <= lgbs_pkg::ST_OK;
            thr_r    <= TW'(1);
            dim_r    <= 2'd0;
            state_r  <= S_EXT;
          end
        end
        S_EXT: begin
          if ((EW+LW)'(cur_glob) > ext_lim) status_r <= lgbs_pkg::ST_EXTENT;
          if (last_dim) begin
            dim_r <= 2'd0;
            if (status_r != lgbs_pkg::ST_OK || (EW+LW)'(cur_glob) > ext_lim)
              state_r <= S_OUT;
            else
              state_r <= S_BLK;
          end else begin
            dim_r <= dim_r + 2'd1;
          end
        end
        S_BLK: begin
          if (given_r) begin
            blk_r[dim_r] <= BW'(b_sel);
            thr_r        <= thr_mul(thr_r, BW'(b_sel));
            state_r      <= S_BLKW;
          end else begin
            // Automatic mode: blocks start at one and the grid at the extent.
            grid_r[dim_r] <= cur_glob;
            if (last_dim) begin
              dim_r   <= 2'd0;
              thr_r   <= TW'(1);
              state_r <= S_GLOOP;
            end else begin
              dim_r <= dim_r + 2'd1;
            end
          end
        end
        S_BLKW: begin
          if (mdu_rsp.done) begin
            grid_r[dim_r] <= mdu_res[EW-1:0];
            if (last_dim) begin
              if (thr_r > TW'(mt_r)) status_r <= lgbs_pkg::ST_GIVEN_THR;
              state_r <= S_OUT;
            end else begin
              dim_r   <= dim_r + 2'd1;
              state_r <= S_BLK;
            end
          end
        end
        S_GLOOP: begin
          if (grid_r[dim_r] > cur_mg) begin
            n_r      <= grid_r[dim_r];
            x_r      <= EW'(2);
            anchor_r <= EW'(2);
            span_r   <= 40'd2;
            k_r      <= 40'd1;
            f_r      <= EW'(1);
            state_r  <= S_RHO;
          end else begin
            thr_r <= thr_mul(thr_r, blk_r[dim_r]);
            if (last_dim) state_r <= S_AFIN;
            else          dim_r   <= dim_r + 2'd1;
          end
        end
        S_AFIN: begin
          if (thr_r > TW'(mt_r)) status_r <= lgbs_pkg::ST_AUTO_THR;
          state_r <= S_OUT;
        end
        S_RHO: begin
          if ((k_r <= span_r) && (f_r <= EW'(1))) begin
            state_r <= S_SQ;
          end else begin
            // End of a round: double its length and move the anchor.
            span_r   <= {span_r[38:0], 1'b0};
            anchor_r <= x_r;
            k_r      <= 40'd1;
            if (f_r != EW'(1)) state_r <= S_APPLY;
          end
        end
        S_SQ: begin
          if (mdu_rsp.done) state_r <= S_MOD;
        end
        S_MOD: begin
          if (mdu_rsp.done) begin
            x_r     <= x_new;
            ga_r    <= d_abs;
            gb_r    <= n_r;
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (gb_r == '0) begin
            f_r     <= ga_r;
            k_r     <= k_r + 40'd1;
            state_r <= S_RHO;
          end else begin
            state_r <= S_GCDW;
          end
        end
        S_GCDW: begin
          if (mdu_rsp.done) begin
            ga_r    <= gb_r;
            gb_r    <= mdu_rem[EW-1:0];
            state_r <= S_GCD;
          end
        end
        S_APPLY: begin
          if (f_r != n_r) begin
            state_r <= S_EXACT;
          end else begin
            // No proper factor: halve the grid, rounding up, double the block.
            blk_r[dim_r]  <= {blk_r[dim_r][BW-2:0], 1'b0};
            grid_r[dim_r] <= EW'(({1'b0, n_r} + (EW+1)'(1)) >> 1);
            state_r       <= S_GLOOP;
          end
        end
        S_EXACT: begin
          if (mdu_rsp.done) begin
            grid_r[dim_r] <= mdu_res[EW-1:0];
            state_r       <= S_BMUL;
          end
        end
        S_BMUL: begin
          if (mdu_rsp.done) begin
            blk_r[dim_r] <= mdu_res[BW-1:0];
            state_r      <= S_GLOOP;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            if (status_r != lgbs_pkg::ST_OK) begin
              out_data_r <= {4'd0, status_r, 186'd0};
            end else begin
              out_data_r <= {4'd0, status_r,
                             blk_r[2][EW-1:0], blk_r[1][EW-1:0], blk_r[0][EW-1:0],
                             grid_r[2], grid_r[1], grid_r[0]};
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/lgbs_mdu.sv */
// Shared multiply/divide unit: shift-add multiply (34 steps) and restoring
// divide of a 64-bit dividend (64 steps), one step per cycle.
// Depends on lgbs_pkg.
module lgbs_mdu (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lgbs_pkg::mdu_req_t        req,
  input  logic [63:0]               opa,
  input  logic [lgbs_pkg::BLK_W-1:0] opb,
  output lgbs_pkg::mdu_rsp_t        rsp,
  output logic [63:0]               res,
  output logic [lgbs_pkg::BLK_W-1:0] rem
);

  logic                       busy_r;
  logic                       done_r;
  lgbs_pkg::mdu_op_t          op_r;
  logic [6:0]                 cnt_r;
  logic [63:0]                acc_r;
  logic [63:0]                a_r;
  logic [lgbs_pkg::BLK_W-1:0] b_r;
  logic [lgbs_pkg::BLK_W-1:0] rem_r;
  logic [lgbs_pkg::BLK_W:0]   trial;
  logic [lgbs_pkg::BLK_W:0]   diff;
  logic                       fits;

  assign trial = {rem_r, a_r[63]};
  assign diff  = trial - {1'b0, b_r};
  assign fits  = (trial >= {1'b0, b_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        a_r    <= opa;
        b_r    <= opb;
        acc_r  <= '0;
        rem_r  <= '0;
        cnt_r  <= (req.op == lgbs_pkg::MDU_MUL) ? 7'(lgbs_pkg::BLK_W) : 7'd64;
      end else if (busy_r) begin
        if (op_r == lgbs_pkg::MDU_MUL) begin
          if (b_r[0]) acc_r <= acc_r + a_r;
          a_r <= {a_r[62:0], 1'b0};
          b_r <= {1'b0, b_r[lgbs_pkg::BLK_W-1:1]};
        end else begin
          if (fits) rem_r <= diff[lgbs_pkg::BLK_W-1:0];
          else      rem_r <= trial[lgbs_pkg::BLK_W-1:0];
          a_r   <= {a_r[62:0], 1'b0};
          acc_r <= {acc_r[62:0], fits};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign res      = acc_r;
  assign rem      = rem_r;

endmodule

/* test/launch_grid_block_splitter_tb.sv */
// Testbench for the launch grid block splitter: stream requests in, check each result beat.
// Keeps its own predictor and copy of the limit registers; depends on rtl/lgbs_pkg.sv and
// the block launch_grid_block_splitter.
module launch_grid_block_splitter_tb;

  typedef struct {
    logic [1:0]      dims;
    logic [lgbs_pkg::EXT_W-1:0] glob [3];
    logic            tiled;
    logic [lgbs_pkg::EXT_W-1:0] tile [3];
  } launch_req_t;

  typedef struct {
    logic [lgbs_pkg::EXT_W-1:0] grid [3];
    logic [lgbs_pkg::EXT_W-1:0] blk [3];
    logic [1:0]      status;
  } launch_split_t;

  localparam longint unsigned SAT32 = 64'hFFFF_FFFF;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [191:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [30:0]  cfg_data;

  // The testbench's own copy of the limit registers, updated on every accepted cfg beat.
  longint unsigned lim_block [3];
  longint unsigned lim_grid [3];
  longint unsigned lim_threads;

  launch_split_t pending_splits [$];
  int            mismatches;
  bit            steady;       // when set, neither side idles
  int            sink_holdoff; // cycles for which the receiver keeps out_tready low

  launch_grid_block_splitter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A hard ceiling on the run. Even the slowest correct run, with every factoring request
  // taking its full rho search, finishes well inside this.
  initial begin
    #400000000;
    $display("Verification failed");
    $finish;
  end

  function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
    longint unsigned r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Brent's variant of Pollard rho; gives n itself when no proper divisor turns up.
  function automatic longint unsigned rho_factor(longint unsigned n);
    longint unsigned anchor, span, x, f, d, k;
    anchor = 2; span = 2; x = 2; f = 1;
    if (n < 2) return n;
    while (f == 1) begin
      for (k = 1; k <= span && f <= 1; k++) begin
        x = (x * x + 1) % n;
        d = (x >= anchor) ? x - anchor : anchor - x;
        f = gcd_of(d, n);
      end
      span = span * 2;
      anchor = x;
    end
    return f;
  endfunction

  function automatic longint unsigned sat_product(longint unsigned a, longint unsigned b);
    if (a > SAT32) a = SAT32;
    if (b > SAT32) b = SAT32;
    a = a * b;
    return (a > SAT32) ? SAT32 : a;
  endfunction

  // Works out the grid and block split that the block should return for one request.
  function automatic launch_split_t split_launch(launch_req_t r);
    launch_split_t   res;
    longint unsigned gl [3];
    longint unsigned lc [3];
    longint unsigned gr [3];
    longint unsigned bk [3];
    longint unsigned thr, b, t, p, g;
    int              nd;
    logic [1:0]      st;
    nd  = (r.dims == 2'd0) ? 1 : int'(r.dims);
    st  = lgbs_pkg::ST_OK;
    thr = 1;
    for (int i = 0; i < 3; i++) begin
      gl[i] = (r.glob[i] == '0) ? 64'd1 : 64'(r.glob[i]);
      lc[i] = (r.tile[i] == '0) ? 64'd1 : 64'(r.tile[i]);
      gr[i] = 1;
      bk[i] = 1;
    end
    for (int i = 0; i < nd; i++)
      if (gl[i] > lim_block[i] * lim_grid[i]) st = lgbs_pkg::ST_EXTENT;
    if (st == lgbs_pkg::ST_OK) begin
      for (int i = 0; i < nd; i++) begin
        b = (gl[i] < lim_block[i]) ? gl[i] : lim_block[i];
        t = r.tiled ? lc[i] : 64'd1;
        if (t < b) b = t;
        bk[i] = b;
        thr   = sat_product(thr, b);
        gr[i] = (gl[i] + b - 1) / b;
      end
      if (r.tiled) begin
        if (thr > lim_threads) st = lgbs_pkg::ST_GIVEN_THR;
      end else begin
        thr = 1;
        for (int i = 0; i < nd; i++) begin
          g = gr[i];
          while (g > lim_grid[i]) begin
            p = rho_factor(g);
            if (p != g) begin
              gr[i] = g / p;
              bk[i] = bk[i] * p;
            end else begin
              bk[i] = bk[i] << 1;
              gr[i] = (g + 1) / 2;
            end
            g = gr[i];
          end
          thr = sat_product(thr, bk[i]);
        end
        if (thr > lim_threads) st = lgbs_pkg::ST_AUTO_THR;
      end
    end
    for (int i = 0; i < 3; i++) begin
      res.grid[i] = (st != lgbs_pkg::ST_OK) ? '0 : gr[i][lgbs_pkg::EXT_W-1:0];
      res.blk[i]  = (st != lgbs_pkg::ST_OK) ? '0 : bk[i][lgbs_pkg::EXT_W-1:0];
    end
    res.status = st;
    return res;
  endfunction

  // Receiver: random idling, a long hold-off when asked, and none at all in a steady stretch.
  always @(negedge clk) begin
    if (sink_holdoff > 0) begin
      sink_holdoff <= sink_holdoff - 1;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 36);
    end
  end

  // Each result beat is compared with the oldest outstanding split.
  always @(posedge clk) begin
    launch_split_t want;
    launch_split_t got;
    if (rst_n && out_tvalid && out_tready) begin
      for (int i = 0; i < 3; i++) begin
        got.grid[i] = out_tdata[i*31 +: 31];
        got.blk[i]  = out_tdata[93 + i*31 +: 31];
      end
      got.status = out_tdata[187:186];
      if (pending_splits.size() == 0) begin
        $display("%0t: result beat with no request outstanding, status %0d grid_x %0d",
                 $time, got.status, got.grid[0]);
        mismatches++;
      end else begin
        want = pending_splits.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          mismatches++;
        end
        for (int i = 0; i < 3; i++) begin
          if (got.grid[i] !== want.grid[i]) begin
            $display("%0t: grid[%0d] expected %0d actual %0d",
                     $time, i, want.grid[i], got.grid[i]);
            mismatches++;
          end
          if (got.blk[i] !== want.blk[i]) begin
            $display("%0t: block[%0d] expected %0d actual %0d",
                     $time, i, want.blk[i], got.blk[i]);
            mismatches++;
          end
        end
      end
    end
  end

  // Sends one request beat, with a random gap first unless the stretch is steady. The
  // expected split is queued at the edge where the beat is taken.
  task automatic send_launch(launch_req_t r);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.tiled;
    in_tdata  <= {4'b0, r.tile[2], r.tile[1], r.tile[0], r.glob[2], r.glob[1], r.glob[0],
                  r.dims};
    do @(posedge clk); while (!in_tready);
    pending_splits.insert(pending_splits.size(), split_launch(r));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_splits.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Writes one limit register; only called while the block is idle.
  task automatic write_limit(logic [2:0] idx, logic [30:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lgbs_pkg::REG_MAX_BLOCK_X: lim_block[0] = 64'(value[lgbs_pkg::LIM_W-1:0]);
      lgbs_pkg::REG_MAX_BLOCK_Y: lim_block[1] = 64'(value[lgbs_pkg::LIM_W-1:0]);
      lgbs_pkg::REG_MAX_BLOCK_Z: lim_block[2] = 64'(value[lgbs_pkg::LIM_W-1:0]);
      lgbs_pkg::REG_MAX_GRID_X:  lim_grid[0]  = 64'(value);
      lgbs_pkg::REG_MAX_GRID_Y:  lim_grid[1]  = 64'(value);
      lgbs_pkg::REG_MAX_GRID_Z:  lim_grid[2]  = 64'(value);
      lgbs_pkg::REG_MAX_THREADS: lim_threads  = 64'(value[lgbs_pkg::LIM_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_limits(int bx, int by, int bz, int gx, int gy, int gz, int thr);
    write_limit(lgbs_pkg::REG_MAX_BLOCK_X, 31'(bx));
    write_limit(lgbs_pkg::REG_MAX_BLOCK_Y, 31'(by));
    write_limit(lgbs_pkg::REG_MAX_BLOCK_Z, 31'(bz));
    write_limit(lgbs_pkg::REG_MAX_GRID_X, 31'(gx));
    write_limit(lgbs_pkg::REG_MAX_GRID_Y, 31'(gy));
    write_limit(lgbs_pkg::REG_MAX_GRID_Z, 31'(gz));
    write_limit(lgbs_pkg::REG_MAX_THREADS, 31'(thr));
  endtask

  // An extent of mixed size: mostly small, sometimes mid, full width, zero or the maximum.
  function automatic logic [30:0] pick_extent();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 31'h7FFF_FFFF;
      2, 3:    return 31'($urandom());
      4, 5:    return 31'($urandom_range(65535, 1));
      default: return 31'($urandom_range(64, 1));
    endcase
  endfunction

  // A random request. In automatic mode an extent far above its grid limit is pulled down,
  // so that rho factoring is only ever asked of small numbers and the run stays short.
  function automatic launch_req_t random_launch();
    launch_req_t r;
    r.dims  = 2'($urandom_range(3));
    r.tiled = 1'($urandom_range(1));
    for (int i = 0; i < 3; i++) begin
      r.glob[i] = pick_extent();
      r.tile[i] = pick_extent();
      if (!r.tiled && r.glob[i] > lim_grid[i] && r.glob[i] > 66000)
        r.glob[i] = 31'($urandom_range(2000, 1));
    end
    return r;
  endfunction

  function automatic launch_req_t make_launch(int dims, bit tiled, int gx, int gy, int gz,
                                              int lx, int ly, int lz);
    launch_req_t r;
    r.dims = 2'(dims); r.tiled = tiled;
    r.glob[0] = 31'(gx); r.glob[1] = 31'(gy); r.glob[2] = 31'(gz);
    r.tile[0] = 31'(lx); r.tile[1] = 31'(ly); r.tile[2] = 31'(lz);
    return r;
  endfunction

  // Directed requests at reset limits: each dimension count including zero, zero extents and
  // tiles, tiles above and below the limits, extent overflow in the y and z dimensions, too
  // many given threads and the largest values of every field.
  task automatic test_directed();
    send_launch(make_launch(0, 0, 100, 5, 5, 1, 1, 1));
    send_launch(make_launch(1, 0, 0, 0, 0, 0, 0, 0));
    send_launch(make_launch(2, 1, 1000, 300, 7, 16, 16, 1));
    send_launch(make_launch(3, 1, 1000, 300, 70, 8, 8, 4));
    send_launch(make_launch(3, 1, 0, 0, 0, 0, 0, 0));
    send_launch(make_launch(1, 1, 5000, 1, 1, 31'h7FFF_FFFF, 1, 1));
    send_launch(make_launch(3, 1, 4096, 4096, 4096, 64, 64, 64));
    send_launch(make_launch(2, 1, 2048, 2048, 1, 32, 33, 1));
    send_launch(make_launch(1, 0, 31'h7FFF_FFFF, 1, 1, 5, 5, 5));
    send_launch(make_launch(2, 0, 10, 65536, 1, 1, 1, 1));
    send_launch(make_launch(3, 0, 10, 10, 65537, 1, 1, 1));
    send_launch(make_launch(3, 0, 10, 10, 131070, 1, 1, 1));
    send_launch(make_launch(2, 0, 1, 31'h7FFF_FFFF, 1, 1, 1, 1));
    send_launch(make_launch(3, 0, 1, 1, 31'h7FFF_FFFF, 1, 1, 1));
    send_launch(make_launch(3, 1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_launch(make_launch(2, 1, 1024, 1024, 9, 1024, 1024, 9));
    wait_idle();
  endtask

  // Small grid limits force the rho path: composites, primes that need halving and
  // results whose thread totals break the limit.
  task automatic test_factoring();
    write_all_limits(1024, 1024, 1024, 7, 1, 3, 1024);
    send_launch(make_launch(1, 0, 60, 1, 1, 1, 1, 1));
    send_launch(make_launch(1, 0, 251, 1, 1, 1, 1, 1));
    send_launch(make_launch(2, 0, 210, 97, 1, 1, 1, 1));
    send_launch(make_launch(3, 0, 8, 12, 257, 1, 1, 1));
    send_launch(make_launch(3, 0, 1000, 900, 800, 1, 1, 1));
    for (int n = 0; n < 20; n++)
      send_launch(make_launch($urandom_range(3, 1), 0, $urandom_range(1000, 1),
                              $urandom_range(1000, 1), $urandom_range(1000, 1), 1, 1, 1));
    wait_idle();
  endtask

  // Limits at extremes: the smallest everywhere, then the largest grid limits.
  task automatic test_limit_extremes();
    write_all_limits(1, 1, 1, 1, 1, 1, 1);
    send_launch(make_launch(3, 0, 1, 1, 1, 1, 1, 1));
    send_launch(make_launch(3, 1, 1, 1, 1, 5, 5, 5));
    send_launch(make_launch(1, 0, 2, 1, 1, 1, 1, 1));
    send_launch(make_launch(3, 1, 1, 1, 2, 1, 1, 1));
    wait_idle();
    write_all_limits(1024, 1024, 1024, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1024);
    for (int n = 0; n < 15; n++) send_launch(random_launch());
    wait_idle();
  endtask

  // Random traffic under a few random limit settings, then under the reset values.
  task automatic test_random();
    for (int phase = 0; phase < 3; phase++) begin
      write_all_limits($urandom_range(1024, 1), $urandom_range(1024, 1),
                       $urandom_range(1024, 1), $urandom_range(70000, 1),
                       $urandom_range(70000, 1), $urandom_range(70000, 1),
                       $urandom_range(1024, 1));
      steady = (phase == 1);
      for (int n = 0; n < 20; n++) send_launch(random_launch());
      wait_idle();
    end
    steady = 1'b0;
    write_all_limits(1024, 1024, 64, 31'h7FFF_FFFF, 65535, 65535, 1024);
    for (int n = 0; n < 12; n++) send_launch(random_launch());
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so the block
  // fills up and stalls its input; then the sender pauses until every result is in.
  task automatic test_backpressure();
    @(negedge clk);
    sink_holdoff = 400;
    for (int n = 0; n < 8; n++) send_launch(random_launch());
    wait_idle();
    for (int n = 0; n < 6; n++) send_launch(random_launch());
    wait_idle();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    out_tready   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = lgbs_pkg::REG_MAX_BLOCK_X;
    cfg_data     = '0;
    steady       = 1'b0;
    sink_holdoff = 0;
    mismatches   = 0;
    lim_block[0] = 1024; lim_block[1] = 1024; lim_block[2] = 64;
    lim_grid[0]  = 64'h7FFF_FFFF; lim_grid[1] = 65535; lim_grid[2] = 65535;
    lim_threads  = 1024;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_factoring();
    test_limit_extremes();
    test_random();
    test_backpressure();

    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
